FILE: rtl/rpvs_pkg.sv
// Package with the constants, types and helpers of the random probe victim selector.
`default_nettype none
package rpvs_pkg;

   localparam int FRAME_COUNT = 64;

   localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int REM_W = IDX_W + 1;
   localparam int CNT_W = $clog2(FRAME_COUNT + 1);
   localparam bit FRAME_POW2 = ((FRAME_COUNT & (FRAME_COUNT - 1)) == 0);

   localparam int SEED_W = 31;
   localparam int FRAME_IDX_W = 6;
   localparam int COMMAND_W = 2;
   localparam int PAGE_ADDR_W = 64;

   localparam logic [SEED_W-1:0] LCG_MUL_LO = 31'h5EECE66D;
   localparam logic [SEED_W-1:0] LCG_ADD = 31'h0000000B;
   localparam logic [SEED_W-1:0] SEED_RESET = 31'd2022;
   localparam logic [31:0] KERNEL_HIGH = 32'hFFFFFFC0;

   localparam logic [COMMAND_W-1:0] CMD_ASSIGN = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_VICTIM = 2'd2;

   typedef logic [IDX_W-1:0] frame_pos_type;

   function automatic logic addr_swappable(input logic [PAGE_ADDR_W-1:0] addr);
      addr_swappable = (addr != '0) && (addr[63:32] != KERNEL_HIGH);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/rpvs_if.sv
// Valid/ready channel interfaces for the command and result transactions.
`default_nettype none
interface rpvs_req_if;
   logic valid;
   logic ready;
   logic [rpvs_pkg::COMMAND_W-1:0] command;
   logic [rpvs_pkg::FRAME_IDX_W-1:0] frame_index;
   logic [rpvs_pkg::PAGE_ADDR_W-1:0] page_address;

   modport source (output valid, output command, output frame_index, output page_address,
                   input ready);
   modport sink (input valid, input command, input frame_index, input page_address,
                 output ready);
endinterface

interface rpvs_rsp_if;
   logic valid;
   logic ready;
   logic [rpvs_pkg::FRAME_IDX_W-1:0] victim_index;
   logic found;

   modport source (output valid, output victim_index, output found, input ready);
   modport sink (input valid, input victim_index, input found, output ready);
endinterface
`default_nettype wire

FILE: rtl/rpvs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module rpvs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: rtl/random_probe_victim_select_top.sv
// Top level of the random probe victim selector: command decode, seed, modulo and frame scan.
// Assign, release and unused commands give no result.
// A victim pick goes from the accepting cycle through a seed step, a bit-serial remainder
// step when the frame count is not a power of two, a scan that probes frames in turn until a
// swappable one is found or every frame was probed, and a load of the result register, which
// waits until the previous result is taken; the one read port sets the scan rate.
// After reset a clearing pass writes every frame flag before any transaction.
`default_nettype none
module random_probe_victim_select_top (
   input  wire logic  clock,
   input  wire logic  reset,
   rpvs_req_if.sink   req_channel,
   rpvs_rsp_if.source rsp_channel
);
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SEED  = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   localparam int IDX_W = rpvs_pkg::IDX_W;
   localparam int REM_W = rpvs_pkg::REM_W;
   localparam int CNT_W = rpvs_pkg::CNT_W;
   localparam int SEED_W = rpvs_pkg::SEED_W;
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(rpvs_pkg::FRAME_COUNT - 1);
   localparam logic [CNT_W-1:0] ALL_PROBES = CNT_W'(rpvs_pkg::FRAME_COUNT);
   localparam logic [REM_W-1:0] FRAME_COUNT_R = REM_W'(rpvs_pkg::FRAME_COUNT);
   localparam logic [SEED_W-1:0] POS_MASK = SEED_W'(rpvs_pkg::FRAME_COUNT - 1);

   logic [2:0] state_ff, state_in;
   logic [SEED_W-1:0] seed_ff, seed_in;
   logic [SEED_W-1:0] prod_ff, prod_in;
   logic [SEED_W-1:0] mod_sh_ff, mod_sh_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [4:0] bit_cnt_ff, bit_cnt_in;
   rpvs_pkg::frame_pos_type probe_pos_ff, probe_pos_in;
   rpvs_pkg::frame_pos_type pend_pos_ff, pend_pos_in;
   logic pend_ff, pend_in;
   logic [CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic [rpvs_pkg::FRAME_IDX_W-1:0] res_victim_ff, res_victim_in;
   logic res_found_ff, res_found_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [rpvs_pkg::FRAME_IDX_W-1:0] rsp_victim_ff, rsp_victim_in;
   logic rsp_found_ff, rsp_found_in;

   logic [2*SEED_W-1:0] product;
   logic [SEED_W-1:0] seed_next;
   logic [REM_W-1:0] rem_shift;
   logic req_fire;
   logic in_range;
   logic issue;
   logic hit;
   logic wr_en;
   rpvs_pkg::frame_pos_type wr_addr;
   logic wr_data;
   logic rd_data;
   rpvs_pkg::frame_pos_type pos_step;

   assign req_channel.ready = (state_ff == ST_IDLE);
   assign req_fire = req_channel.valid && (state_ff == ST_IDLE);
   assign in_range = (32'(req_channel.frame_index) < rpvs_pkg::FRAME_COUNT);

   assign product = seed_ff * rpvs_pkg::LCG_MUL_LO;
   assign seed_next = prod_ff + rpvs_pkg::LCG_ADD;
   assign rem_shift = {rem_ff[REM_W-2:0], mod_sh_ff[SEED_W-1]};
   assign pos_step = (probe_pos_ff == LAST_POS) ? '0 : probe_pos_ff + 1'b1;
   assign issue = (state_ff == ST_SCAN) && (issue_cnt_ff != ALL_PROBES);
   assign hit = (state_ff == ST_SCAN) && pend_ff && rd_data;

   assign rsp_channel.valid = rsp_valid_ff;
   assign rsp_channel.victim_index = rsp_victim_ff;
   assign rsp_channel.found = rsp_found_ff;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = probe_pos_ff;
      wr_data = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_IDLE: begin
            wr_addr = IDX_W'(req_channel.frame_index);
            if (req_fire && in_range) begin
               if (req_channel.command == rpvs_pkg::CMD_ASSIGN) begin
                  wr_en = 1'b1;
                  wr_data = rpvs_pkg::addr_swappable(req_channel.page_address);
               end else if (req_channel.command == rpvs_pkg::CMD_RELEASE) begin
                  wr_en = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            wr_addr = pend_pos_ff;
            wr_en = hit;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      seed_in = seed_ff;
      prod_in = prod_ff;
      mod_sh_in = mod_sh_ff;
      rem_in = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      probe_pos_in = probe_pos_ff;
      pend_pos_in = pend_pos_ff;
      pend_in = 1'b0;
      issue_cnt_in = issue_cnt_ff;
      res_victim_in = res_victim_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;
      rsp_victim_in = rsp_victim_ff;
      rsp_found_in = rsp_found_ff;
      case (state_ff)
         ST_CLEAR: begin
            probe_pos_in = pos_step;
            if (probe_pos_ff == LAST_POS) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && req_channel.command == rpvs_pkg::CMD_VICTIM) begin
               prod_in = product[SEED_W-1:0];
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            seed_in = seed_next;
            issue_cnt_in = '0;
            if (rpvs_pkg::FRAME_POW2) begin
               probe_pos_in = IDX_W'(seed_next & POS_MASK);
               state_in = ST_SCAN;
            end else begin
               mod_sh_in = seed_next;
               rem_in = '0;
               bit_cnt_in = '0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            rem_in = (rem_shift >= FRAME_COUNT_R) ? rem_shift - FRAME_COUNT_R : rem_shift;
            mod_sh_in = {mod_sh_ff[SEED_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == 5'(SEED_W - 1)) begin
               probe_pos_in = rem_in[IDX_W-1:0];
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_victim_in = rpvs_pkg::FRAME_IDX_W'(pend_pos_ff);
               res_found_in = 1'b1;
               state_in = ST_RESP;
            end else if (!pend_ff && !issue) begin
               res_victim_in = '0;
               res_found_in = 1'b0;
               state_in = ST_RESP;
            end else if (issue) begin
               pend_in = 1'b1;
               pend_pos_in = probe_pos_ff;
               probe_pos_in = pos_step;
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_channel.ready) begin
               rsp_valid_in = 1'b1;
               rsp_victim_in = res_victim_ff;
               rsp_found_in = res_found_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         seed_ff <= rpvs_pkg::SEED_RESET;
         probe_pos_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seed_ff <= seed_in;
         probe_pos_ff <= probe_pos_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      mod_sh_ff <= mod_sh_in;
      rem_ff <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      pend_pos_ff <= pend_pos_in;
      issue_cnt_ff <= issue_cnt_in;
      res_victim_ff <= res_victim_in;
      res_found_ff <= res_found_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_found_ff <= rsp_found_in;
   end

   rpvs_ram #(
      .WIDTH(1),
      .DEPTH(rpvs_pkg::FRAME_COUNT)
   ) u_swappable_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(issue),
      .rd_addr(probe_pos_ff),
      .rd_data(rd_data)
   );
endmodule
`default_nettype wire

FILE: dv/rpvs_checker.sv
// Checker that watches both channels, predicts each victim pick and compares the results.
`default_nettype none
module rpvs_checker (
   input  wire logic clock,
   input  wire logic reset,
   rpvs_req_if       req_mon,
   rpvs_rsp_if       rsp_mon,
   output int        failures,
   output int        pending
);
   import rpvs_pkg::*;

   localparam logic [63:0] SEED_MULTIPLIER = 64'h5DEECE66D;

   typedef struct packed {
      logic [FRAME_IDX_W-1:0] victim_index;
      logic                   found;
   } victim_result_type;

   bit                frame_usable [FRAME_COUNT];
   logic [SEED_W-1:0] probe_seed;
   victim_result_type victim_queue [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR: %s: got %0h, expected %0h", what, got, want);
      failures++;
   endtask

   task automatic clear_frames();
      for (int i = 0; i < FRAME_COUNT; i++) frame_usable[i] = 1'b0;
      probe_seed = SEED_RESET;
      victim_queue.delete();
   endtask

   task automatic pick_victim();
      logic [63:0]       product;
      int                pos;
      victim_result_type res;
      product = SEED_MULTIPLIER * {33'd0, probe_seed} + {33'd0, LCG_ADD};
      probe_seed = product[SEED_W-1:0];
      pos = int'(probe_seed % FRAME_COUNT);
      res = '0;
      for (int k = 0; k < FRAME_COUNT; k++) begin
         if (!res.found && frame_usable[pos]) begin
            frame_usable[pos] = 1'b0;
            res.victim_index = pos[FRAME_IDX_W-1:0];
            res.found = 1'b1;
         end
         pos = (pos + 1 >= FRAME_COUNT) ? 0 : pos + 1;
      end
      victim_queue.push_back(res);
   endtask

   always @(posedge clock) begin
      victim_result_type want;
      if (reset) begin
         clear_frames();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (victim_queue.size() == 0) begin
               report_mismatch("result transaction with nothing expected",
                               {57'd0, rsp_mon.victim_index, rsp_mon.found}, 64'd0);
            end else begin
               want = victim_queue.pop_front();
               if (rsp_mon.victim_index !== want.victim_index)
                  report_mismatch("victim_index", 64'(rsp_mon.victim_index),
                                  64'(want.victim_index));
               if (rsp_mon.found !== want.found)
                  report_mismatch("found", 64'(rsp_mon.found), 64'(want.found));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            case (req_mon.command)
               CMD_ASSIGN: begin
                  if (int'(req_mon.frame_index) < FRAME_COUNT)
                     frame_usable[req_mon.frame_index] =
                        (req_mon.page_address != 64'd0) &&
                        (req_mon.page_address[63:32] != KERNEL_HIGH);
               end
               CMD_RELEASE: begin
                  if (int'(req_mon.frame_index) < FRAME_COUNT)
                     frame_usable[req_mon.frame_index] = 1'b0;
               end
               CMD_VICTIM: begin
                  pick_victim();
               end
               default: begin
               end
            endcase
         end
      end
      pending = victim_queue.size();
   end
endmodule
`default_nettype wire

FILE: dv/tb_random_probe_victim_select_top.sv
// Testbench top that drives command transactions, paces the result channel and gives the verdict.
`default_nettype none
module tb_random_probe_victim_select_top;
   import rpvs_pkg::*;

   localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 1500;
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASE_ITEMS = 300;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   int   send_idle_pct;
   int   recv_stall_pct;
   bit   hold_go;
   bit   hold_seen;
   int   hold_left;

   rpvs_req_if req_bus ();
   rpvs_rsp_if rsp_bus ();

   random_probe_victim_select_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus)
   );

   rpvs_checker u_checker (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req_bus),
      .rsp_mon  (rsp_bus),
      .failures (failures),
      .pending  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("random_probe_victim_select_top: mismatch");
      $finish;
   end

   always @(negedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [63:0] random_page_address();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return 64'd0;
      if (pick < 25) return {KERNEL_HIGH, 32'($urandom)};
      if (pick < 35) return 64'(32'($urandom));
      return {32'($urandom), 32'($urandom)};
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_cmd(input logic [COMMAND_W-1:0] cmd,
                           input logic [FRAME_IDX_W-1:0] idx,
                           input logic [PAGE_ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.frame_index <= idx;
      req_bus.page_address <= addr;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_burst(output int count);
      int pick;
      int fill;
      pick = $urandom_range(99);
      count = 0;
      if (pick < 25) begin
         fill = $urandom_range(12, 2);
         repeat (fill) begin
            send_cmd(CMD_ASSIGN, 6'($urandom), {32'($urandom), 32'($urandom)} | 64'd1);
            count++;
         end
         repeat ($urandom_range(fill + 2, 1)) begin
            send_cmd(CMD_VICTIM, 6'($urandom), {32'($urandom), 32'($urandom)});
            count++;
         end
      end else if (pick < 60) begin
         send_cmd(CMD_ASSIGN, 6'($urandom), random_page_address());
         count = 1;
      end else if (pick < 72) begin
         send_cmd(CMD_RELEASE, 6'($urandom), {32'($urandom), 32'($urandom)});
         count = 1;
      end else if (pick < 94) begin
         send_cmd(CMD_VICTIM, 6'($urandom), {32'($urandom), 32'($urandom)});
         count = 1;
      end else begin
         send_cmd(CMD_UNUSED, 6'($urandom), {32'($urandom), 32'($urandom)});
         count = 1;
      end
   endtask

   initial begin
      int sent;
      int burst;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_ASSIGN;
      req_bus.frame_index = '0;
      req_bus.page_address = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_go = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty pool, address classes, unused command, release and reassign.
      send_cmd(CMD_VICTIM, 6'd0, 64'd0);
      send_cmd(CMD_ASSIGN, 6'd0, 64'd0);
      send_cmd(CMD_ASSIGN, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
      send_cmd(CMD_ASSIGN, 6'd5, {KERNEL_HIGH, 32'h0000_1000});
      send_cmd(CMD_ASSIGN, 6'd10, {KERNEL_HIGH, 32'h0000_0000});
      send_cmd(CMD_ASSIGN, 6'd1, 64'd1);
      send_cmd(CMD_ASSIGN, 6'd2, 64'hFFFF_FFBF_FFFF_FFFF);
      send_cmd(CMD_ASSIGN, 6'd3, 64'hFFFF_FFC1_0000_0000);
      send_cmd(CMD_UNUSED, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
      send_cmd(CMD_RELEASE, 6'd1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_cmd(CMD_RELEASE, 6'd40, 64'd0);
      send_cmd(CMD_ASSIGN, 6'd20, 64'h0000_0001_0000_0000);
      send_cmd(CMD_ASSIGN, 6'd20, {KERNEL_HIGH, 32'hFFFF_FFFF});
      send_cmd(CMD_VICTIM, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
      send_cmd(CMD_VICTIM, 6'd0, 64'd0);
      send_cmd(CMD_VICTIM, 6'd0, 64'd0);
      send_cmd(CMD_VICTIM, 6'd0, 64'd0);
      send_cmd(CMD_ASSIGN, 6'd0, 64'h8000_0000_0000_0000);
      send_cmd(CMD_VICTIM, 6'd0, 64'd0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            random_burst(burst);
            sent += burst;
         end
         if (phase == 0) begin
            // The result channel is held off while victim picks keep coming.
            hold_go = ~hold_go;
            repeat (24) begin
               send_cmd(CMD_ASSIGN, 6'($urandom), {32'($urandom), 32'($urandom)} | 64'd1);
               send_cmd(CMD_VICTIM, 6'($urandom), {32'($urandom), 32'($urandom)});
            end
         end
      end

      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("random_probe_victim_select_top: match");
      end else begin
         $display("random_probe_victim_select_top: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire
